[src/wsdf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wsdf_pkg
// Types and constants shared by the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsdf_pkg;

    // parser phase
    typedef enum logic [2:0] {
        PH_B0  = 3'd0,
        PH_B1  = 3'd1,
        PH_EXT = 3'd2,
        PH_KEY = 3'd3,
        PH_PAY = 3'd4
    } phase_t;

    // event codes carried on the result channel
    typedef enum logic [1:0] {
        EV_PAYLOAD  = 2'd0,
        EV_HEADER   = 2'd1,
        EV_CLOSE    = 2'd2,
        EV_OVERSIZE = 2'd3
    } ev_kind_t;

    localparam logic [3:0] OPC_CLOSE  = 4'h8;
    localparam logic [3:0] OPC_PING   = 4'h9;
    localparam logic [6:0] LEN16_CODE = 7'd126;
    localparam logic [6:0] LEN64_CODE = 7'd127;

    localparam logic [3:0] LEN16_BYTES = 4'd2;
    localparam logic [3:0] LEN64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    localparam int unsigned ACC_W      = 64;
    localparam int unsigned DECL_W     = 63;
    localparam int unsigned CAP_W      = 32;
    localparam int unsigned M_TDATA_W  = 80;

    // register indexes
    localparam logic REG_CAPACITY = 1'b0;

endpackage : wsdf_pkg
`default_nettype wire

[src/websocket_frame_deframer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses a WebSocket byte stream, unmasks the payload and reports events.
// ----------------------------------------------------------------------------
// Usage
// - s_ channel: one raw stream byte per transfer on s_tdata.
// - m_ channel: at most one result per input byte. m_tuser carries the event
//   (payload byte, header done, close frame, payload over buffer), m_tdata the
//   byte and header fields, m_tlast marks the last result of a frame.
// - APB port: register 0 (byte address 0) is the payload capacity, sampled
//   when a header completes. Write it only while the stream is idle.
// Timing
// - one byte accepted every cycle unless a held result waits on m_tready;
//   a result appears on m_ in the cycle after the byte that causes it. Header
//   bytes produce nothing until the header is complete. The per-byte path is
//   one 64-bit decrement/compare on the length and remaining-byte counters.
// Reset
// - synchronous, active low: parser waits for the first header byte, the
//   capacity returns to all ones, the result register is emptied.
// Stall
// - a held result blocks s_tready only when m_tready is low; while the
//   result register drains, the next byte is taken in the same cycle.
// ----------------------------------------------------------------------------
module websocket_frame_deframer
    import wsdf_pkg::*;
#(
    parameter int unsigned LENGTH_WIDTH = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [7:0] stream_byte
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [7:0] payload_byte, [11:8] frame_opcode, [12] final_fragment,
    // [13] is_ping, [14] was_masked, [77:15] declared_length, [79:78] zero
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic [1:0]                m_tuser,   // [1:0] event_kind
    output logic                      m_tlast,   // frame_last
    // configuration
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    // parser state
    phase_t             phase_reg, phase_next;
    logic [3:0]         hcnt_reg, hcnt_next;
    logic [3:0]         opcode_reg, opcode_next;
    logic               fin_reg, fin_next;
    logic               mask_reg, mask_next;
    logic [6:0]         code_reg, code_next;
    logic [ACC_W-1:0]   len_reg, len_next;
    logic [31:0]        key_reg, key_next;
    logic [ACC_W-1:0]   rem_reg, rem_next;
    logic [1:0]         kidx_reg, kidx_next;
    logic               disc_reg, disc_next;
    logic [CAP_W-1:0]   cap_reg;

    // result register
    logic               out_valid_reg;
    ev_kind_t           out_kind_reg;
    logic [7:0]         out_byte_reg;
    logic [3:0]         out_opcode_reg;
    logic               out_fin_reg;
    logic               out_masked_reg;
    logic [DECL_W-1:0]  out_len_reg;
    logic               out_last_reg;

    // combinational results
    logic               acc;
    logic [7:0]         b;
    logic               ext_code;
    logic [3:0]         hcnt_inc;
    logic [3:0]         ext_need;
    logic [ACC_W-1:0]   ext_len;
    logic               ext_done;
    logic               key_done;
    logic               finish_now;
    logic [ACC_W-1:0]   finish_len;
    logic               too_wide;
    logic               over_cap;
    logic [ACC_W-1:0]   rem_dec;
    logic               pay_last;
    logic [7:0]         key_byte;
    logic               res_valid;
    ev_kind_t           res_kind;
    logic [7:0]         res_byte;
    logic               res_last;

    // handshakes
    assign acc      = s_tvalid && s_tready;
    assign s_tready = !out_valid_reg || m_tready;
    assign b        = s_tdata;

    // header helpers
    assign ext_code = (b[6:0] == LEN16_CODE) || (b[6:0] == LEN64_CODE);
    assign hcnt_inc = hcnt_reg + 4'd1;
    assign ext_need = (code_reg == LEN16_CODE) ? LEN16_BYTES : LEN64_BYTES;
    assign ext_len  = {len_reg[ACC_W-9:0], b};
    assign ext_done = (hcnt_inc >= ext_need);
    assign key_done = (hcnt_inc >= KEY_BYTES);

    // header completes on this byte
    always_comb begin
        finish_now = 1'b0;
        finish_len = len_reg;
        unique case (phase_reg)
            PH_B1: begin
                finish_now = !ext_code && !b[7];
                finish_len = {{(ACC_W-7){1'b0}}, b[6:0]};
            end
            PH_EXT: begin
                finish_now = ext_done && !mask_reg;
                finish_len = ext_len;
            end
            PH_KEY: begin
                finish_now = key_done;
                finish_len = len_reg;
            end
            default: begin
                finish_now = 1'b0;
                finish_len = len_reg;
            end
        endcase
    end

    // length limit checks
    generate
        if (LENGTH_WIDTH < ACC_W) begin : g_narrow
            assign too_wide = |finish_len[ACC_W-1:LENGTH_WIDTH];
        end else begin : g_full
            assign too_wide = 1'b0;
        end
    endgenerate

    assign over_cap = (|finish_len[ACC_W-1:CAP_W]) || (finish_len[CAP_W-1:0] > cap_reg);

    // payload counter
    assign rem_dec  = (rem_reg != '0) ? (rem_reg - {{(ACC_W-1){1'b0}}, 1'b1}) : '0;
    assign pay_last = (rem_dec == '0);

    // key byte for this payload position, first key byte in the top bits
    always_comb begin
        case (kidx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (acc) begin
            unique case (phase_reg)
                PH_B1: begin
                    if (ext_code)      phase_next = PH_EXT;
                    else if (b[7])     phase_next = PH_KEY;
                    else               phase_next = (finish_len == '0) ? PH_B0 : PH_PAY;
                end
                PH_EXT: begin
                    if (!ext_done)     phase_next = PH_EXT;
                    else if (mask_reg) phase_next = PH_KEY;
                    else               phase_next = (finish_len == '0) ? PH_B0 : PH_PAY;
                end
                PH_KEY: begin
                    if (!key_done)     phase_next = PH_KEY;
                    else               phase_next = (finish_len == '0) ? PH_B0 : PH_PAY;
                end
                PH_PAY: begin
                    phase_next = pay_last ? PH_B0 : PH_PAY;
                end
                default: begin
                    phase_next = PH_B1;
                end
            endcase
        end
    end

    // datapath and result
    always_comb begin
        hcnt_next   = hcnt_reg;
        opcode_next = opcode_reg;
        fin_next    = fin_reg;
        mask_next   = mask_reg;
        code_next   = code_reg;
        len_next    = len_reg;
        key_next    = key_reg;
        rem_next    = rem_reg;
        kidx_next   = kidx_reg;
        disc_next   = disc_reg;
        res_valid   = 1'b0;
        res_kind    = EV_PAYLOAD;
        res_byte    = 8'h00;
        res_last    = 1'b0;
        if (acc) begin
            unique case (phase_reg)
                PH_B1: begin
                    mask_next = b[7];
                    code_next = b[6:0];
                    hcnt_next = 4'd0;
                    len_next  = ext_code ? '0 : finish_len;
                end
                PH_EXT: begin
                    len_next  = ext_len;
                    hcnt_next = ext_done ? 4'd0 : hcnt_inc;
                end
                PH_KEY: begin
                    key_next  = {key_reg[23:0], b};
                    hcnt_next = key_done ? 4'd0 : hcnt_inc;
                end
                PH_PAY: begin
                    rem_next = rem_dec;
                    if (!disc_reg) begin
                        kidx_next = kidx_reg + 2'd1;
                        res_valid = 1'b1;
                        res_kind  = EV_PAYLOAD;
                        res_byte  = b ^ key_byte;
                        res_last  = pay_last;
                    end
                end
                default: begin
                    fin_next    = b[7];
                    opcode_next = b[3:0];
                    mask_next   = 1'b0;
                    code_next   = 7'd0;
                    len_next    = '0;
                    key_next    = '0;
                    rem_next    = '0;
                    kidx_next   = 2'd0;
                    disc_next   = 1'b0;
                    hcnt_next   = 4'd0;
                end
            endcase

            // header event: close first, then the length limits
            if (finish_now) begin
                rem_next  = finish_len;
                kidx_next = 2'd0;
                res_valid = 1'b1;
                if (opcode_reg == OPC_CLOSE) begin
                    res_kind  = EV_CLOSE;
                    disc_next = 1'b1;
                    res_last  = 1'b1;
                end else if (too_wide || over_cap) begin
                    res_kind  = EV_OVERSIZE;
                    disc_next = 1'b1;
                    res_last  = 1'b1;
                end else begin
                    res_kind  = EV_HEADER;
                    disc_next = 1'b0;
                    res_last  = (finish_len == '0);
                end
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_B0;
            hcnt_reg   <= 4'd0;
            opcode_reg <= 4'd0;
            fin_reg    <= 1'b0;
            mask_reg   <= 1'b0;
            code_reg   <= 7'd0;
            len_reg    <= '0;
            key_reg    <= '0;
            rem_reg    <= '0;
            kidx_reg   <= 2'd0;
            disc_reg   <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            hcnt_reg   <= hcnt_next;
            opcode_reg <= opcode_next;
            fin_reg    <= fin_next;
            mask_reg   <= mask_next;
            code_reg   <= code_next;
            len_reg    <= len_next;
            key_reg    <= key_next;
            rem_reg    <= rem_next;
            kidx_reg   <= kidx_next;
            disc_reg   <= disc_next;
        end
    end

    // result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_tready) begin
            out_valid_reg <= acc && res_valid;
        end
    end

    // result register payload, loaded with the new header fields
    always_ff @(posedge aclk) begin
        if (acc && res_valid) begin
            out_kind_reg   <= res_kind;
            out_byte_reg   <= res_byte;
            out_opcode_reg <= opcode_next;
            out_fin_reg    <= fin_next;
            out_masked_reg <= mask_next;
            out_len_reg    <= len_next[DECL_W-1:0];
            out_last_reg   <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_len_reg, out_masked_reg,
                       (out_opcode_reg == OPC_PING), out_fin_reg,
                       out_opcode_reg, out_byte_reg};

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= {CAP_W{1'b1}};
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY)) begin
            cap_reg <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? cap_reg : 32'd0;

    // checks on the parser
    a_b0_to_b1: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && phase_reg == PH_B0) |=> (phase_reg == PH_B1))
        else $error("first header byte did not advance to second");

    a_no_discard_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && res_valid) |-> !(phase_reg == PH_PAY && disc_reg))
        else $error("result produced from swallowed payload");

    a_hcnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hcnt_reg <= 4'd7)
        else $error("header byte count out of range");

    a_pay_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAY) |-> (rem_reg != '0))
        else $error("payload phase with no bytes remaining");

endmodule : websocket_frame_deframer
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the WebSocket frame deframer. Frames are built as
// byte streams (short, 16-bit and 64-bit length forms, masked and unmasked,
// close, ping and oversized frames) and sent with random gaps while the
// result side stalls at random. A byte-level parser in the bench predicts
// every event, and each result transfer is checked field by field. The
// capacity register is rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module tb;
    import wsdf_pkg::*;

    localparam int unsigned LEN_W        = 64;
    localparam int unsigned PHASE_BYTES  = 210;
    localparam int unsigned NUM_PHASES   = 6;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_LIMIT  = 400;
    localparam int unsigned TAIL_CYCLES  = 4;
    localparam int unsigned IDLE_PERCENT = 31;
    localparam logic [2:0]  CAP_ADDR     = 3'({REG_CAPACITY, 2'b00});

    // how the payload length is written in the header
    typedef enum int {
        LEN_SHORT,
        LEN_16,
        LEN_64
    } len_form_t;

    // one result transfer as the bench expects it
    typedef struct packed {
        ev_kind_t     kind;
        logic [7:0]   data;
        logic [3:0]   opcode;
        logic         fin;
        logic         ping;
        logic         masked;
        logic [62:0]  length;
        logic         last;
    } frame_event_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata  = 8'h00;   // [7:0] stream_byte
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [7:0] payload_byte, [11:8] frame_opcode, [12] final_fragment,
    // [13] is_ping, [14] was_masked, [77:15] declared_length, [79:78] zero
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;            // [1:0] event_kind
    logic                 m_tlast;            // frame_last
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [2:0]           paddr    = 3'd0;
    logic [31:0]          pwdata   = 32'd0;
    logic [31:0]          prdata;
    logic                 pready;

    // stimulus and expectations
    logic [7:0]           stream_bytes[$];
    frame_event_t         events_due[$];
    frame_event_t         want;
    int unsigned          bytes_queued = 0;
    int unsigned          failures     = 0;
    int unsigned          quiet_cycles = 0;
    logic                 s_taken      = 1'b0;
    logic                 no_idle      = 1'b0;

    // parser state mirrored by the bench
    phase_t               cur_phase    = PH_B0;
    logic [3:0]           hdr_count    = '0;
    logic [3:0]           cur_opcode   = '0;
    logic                 cur_fin      = 1'b0;
    logic                 cur_masked   = 1'b0;
    logic [6:0]           len_sel      = '0;
    logic [63:0]          len_value    = '0;
    logic [31:0]          key_word     = '0;
    logic [63:0]          left_bytes   = '0;
    logic [1:0]           key_pos      = '0;
    logic                 drop_payload = 1'b0;
    logic [31:0]          cap_limit    = 32'hFFFF_FFFF;

    websocket_frame_deframer #(
        .LENGTH_WIDTH(LEN_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 aclk = ~aclk;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
        failures++;
    endtask

    // event fields taken from the header currently held
    function automatic frame_event_t make_event(input ev_kind_t kind, input logic [7:0] data,
                                                input logic last);
        make_event = '{kind: kind, data: data, opcode: cur_opcode, fin: cur_fin,
                       ping: (cur_opcode == OPC_PING), masked: cur_masked,
                       length: len_value[62:0], last: last};
    endfunction

    // header complete: close beats the capacity check, oversize swallows
    task automatic header_complete();
        ev_kind_t kind;
        logic     last;
        last       = (len_value == 64'd0);
        left_bytes = len_value;
        key_pos    = '0;
        if (cur_opcode == OPC_CLOSE) begin
            kind         = EV_CLOSE;
            drop_payload = 1'b1;
            last         = 1'b1;
        end else if ((len_value >> LEN_W) != 64'd0 || len_value > {32'd0, cap_limit}) begin
            kind         = EV_OVERSIZE;
            drop_payload = 1'b1;
            last         = 1'b1;
        end else begin
            kind         = EV_HEADER;
            drop_payload = 1'b0;
        end
        cur_phase = (left_bytes == 64'd0) ? PH_B0 : PH_PAY;
        events_due.push_back(make_event(kind, 8'h00, last));
    endtask

    // length known: the key follows if the mask bit is set
    task automatic length_complete();
        hdr_count = '0;
        if (cur_masked)
            cur_phase = PH_KEY;
        else
            header_complete();
    endtask

    // advance the mirrored parser by one accepted stream byte
    task automatic deframe_byte(input logic [7:0] b);
        logic [3:0] need;
        logic [7:0] kb;
        logic       last;
        case (cur_phase)
            PH_B1: begin
                cur_masked = b[7];
                len_sel    = b[6:0];
                hdr_count  = '0;
                len_value  = '0;
                if (len_sel == LEN16_CODE || len_sel == LEN64_CODE) begin
                    cur_phase = PH_EXT;
                end else begin
                    len_value = 64'(len_sel);
                    length_complete();
                end
            end
            PH_EXT: begin
                need      = (len_sel == LEN16_CODE) ? LEN16_BYTES : LEN64_BYTES;
                len_value = {len_value[55:0], b};
                hdr_count = hdr_count + 4'd1;
                if (hdr_count >= need)
                    length_complete();
            end
            PH_KEY: begin
                key_word  = {key_word[23:0], b};
                hdr_count = hdr_count + 4'd1;
                if (hdr_count >= KEY_BYTES) begin
                    hdr_count = '0;
                    header_complete();
                end
            end
            PH_PAY: begin
                if (left_bytes != 64'd0)
                    left_bytes = left_bytes - 64'd1;
                last = (left_bytes == 64'd0);
                if (last)
                    cur_phase = PH_B0;
                if (!drop_payload) begin
                    kb      = key_word[8*(3-key_pos) +: 8];
                    key_pos = key_pos + 2'd1;
                    events_due.push_back(make_event(EV_PAYLOAD, b ^ kb, last));
                end
            end
            default: begin
                cur_fin      = b[7];
                cur_opcode   = b[3:0];
                cur_masked   = 1'b0;
                len_sel      = '0;
                len_value    = '0;
                key_word     = '0;
                left_bytes   = '0;
                key_pos      = '0;
                drop_payload = 1'b0;
                hdr_count    = '0;
                cur_phase    = PH_B1;
            end
        endcase
    endtask

    function automatic void push_byte(input logic [7:0] b);
        stream_bytes.push_back(b);
        bytes_queued++;
    endfunction

    // queue one frame; count payload bytes follow the header
    task automatic push_frame(input logic [7:0] first, input logic mask_on,
                              input logic [63:0] len, input len_form_t form,
                              input int unsigned count);
        logic [31:0] key;
        key = $urandom;
        push_byte(first);
        case (form)
            LEN_16: begin
                push_byte({mask_on, LEN16_CODE});
                push_byte(len[15:8]);
                push_byte(len[7:0]);
            end
            LEN_64: begin
                push_byte({mask_on, LEN64_CODE});
                for (int i = 7; i >= 0; i--)
                    push_byte(len[8*i +: 8]);
            end
            default: push_byte({mask_on, len[6:0]});
        endcase
        if (mask_on)
            for (int i = 3; i >= 0; i--)
                push_byte(key[8*i +: 8]);
        for (int unsigned i = 0; i < count; i++)
            push_byte(8'($urandom));
    endtask

    // random frame: any first byte, close and ping favoured, mostly short
    task automatic random_frame();
        logic [7:0]  first;
        logic [63:0] len;
        len_form_t   form;
        int unsigned r;
        first = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 12)
            first[3:0] = OPC_CLOSE;
        else if (r < 24)
            first[3:0] = OPC_PING;
        r = $urandom_range(0, 99);
        if (r < 85)
            len = 64'($urandom_range(0, 12));
        else
            len = 64'($urandom_range(13, 125));
        r = $urandom_range(0, 99);
        if (r < 70)
            form = LEN_SHORT;
        else if (r < 85)
            form = LEN_16;
        else
            form = LEN_64;
        push_frame(first, 1'($urandom), len, form, int'(len));
    endtask

    // let every queued byte go and every due event come back
    task automatic wait_drained();
        int unsigned waited;
        waited = 0;
        while (stream_bytes.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (events_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // apb write: setup then access, register taken at the access edge
    task automatic write_capacity(input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        cap_limit = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stream driver: hold the byte until its transfer, then maybe idle
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (stream_bytes.size() != 0 &&
                (no_idle || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= stream_bytes.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // monitor: check results first, then predict from the accepted byte
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_taken <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (events_due.size() == 0) begin
                    report_mismatch("result with no event due, kind", 64'(m_tuser), 64'd0);
                end else begin
                    want = events_due.pop_front();
                    if (m_tuser != want.kind)
                        report_mismatch("event_kind", 64'(m_tuser), 64'(want.kind));
                    if (m_tdata[7:0] != want.data)
                        report_mismatch("payload_byte", 64'(m_tdata[7:0]), 64'(want.data));
                    if (m_tdata[11:8] != want.opcode)
                        report_mismatch("frame_opcode", 64'(m_tdata[11:8]), 64'(want.opcode));
                    if (m_tdata[12] != want.fin)
                        report_mismatch("final_fragment", 64'(m_tdata[12]), 64'(want.fin));
                    if (m_tdata[13] != want.ping)
                        report_mismatch("is_ping", 64'(m_tdata[13]), 64'(want.ping));
                    if (m_tdata[14] != want.masked)
                        report_mismatch("was_masked", 64'(m_tdata[14]), 64'(want.masked));
                    if (m_tdata[77:15] != want.length)
                        report_mismatch("declared_length", 64'(m_tdata[77:15]),
                                        64'(want.length));
                    if (m_tlast != want.last)
                        report_mismatch("frame_last", 64'(m_tlast), 64'(want.last));
                end
            end
            if (s_tvalid && s_tready)
                deframe_byte(s_tdata);
            s_taken <= s_tvalid && s_tready;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        logic [31:0] cap;
        int unsigned start;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed, capacity at its reset value
        push_frame(8'h81, 1'b0, 64'd0, LEN_SHORT, 0);   // zero length, fin set
        push_frame(8'h89, 1'b1, 64'd2, LEN_SHORT, 2);   // masked ping
        push_frame(8'h72, 1'b0, 64'd1, LEN_16, 1);      // rsv bits, no fin, 16-bit form
        push_frame(8'h88, 1'b0, 64'd1, LEN_SHORT, 1);   // close, payload swallowed
        push_frame(8'hFF, 1'b0, 64'd0, LEN_SHORT, 0);   // all ones first byte
        wait_drained();

        // zero capacity: any payload is over buffer
        write_capacity(32'd0);
        push_frame(8'h82, 1'b0, 64'd1, LEN_SHORT, 1);
        push_frame(8'h01, 1'b0, 64'd0, LEN_SHORT, 0);
        wait_drained();

        // close longer than the capacity still reports as close
        write_capacity(32'd2);
        push_frame(8'h88, 1'b0, 64'd3, LEN_SHORT, 3);
        wait_drained();

        // random phases with the capacity changed between them
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       cap = $urandom;
                1:       cap = $urandom_range(0, 24);
                2:       cap = 32'd0;
                3:       cap = 32'hFFFF_FFFF;
                4:       cap = $urandom_range(0, 24);
                default: cap = $urandom_range(25, 130);
            endcase
            write_capacity(cap);
            no_idle = (p == 3);
            start = bytes_queued;
            while (bytes_queued - start < PHASE_BYTES)
                random_frame();
            wait_drained();
            no_idle = 1'b0;
        end

        // 64-bit length with its top bit set: over buffer, payload never ends
        write_capacity(32'hFFFF_FFFF);
        push_frame(8'h82, 1'b1, 64'hFEDC_BA98_7654_3210, LEN_64, 3);
        wait_drained();

        if (events_due.size() != 0)
            report_mismatch("events still due at end", 64'd0, 64'(events_due.size()));
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
